// ===== rtl/thp_sensor_compensation_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the compensation core
// Same-cycle and next-cycle implication checks, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THP_SENSOR_COMPENSATION_CORE_ASSERT_SVH
`define THP_SENSOR_COMPENSATION_CORE_ASSERT_SVH

// check cons in the cycle of ante
`define THP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thp_comp: same-cycle check failed");

// check cons in the cycle after ante
`define THP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thp_comp: next-cycle check failed");

`endif

// ===== rtl/thp_comp_pkg.sv =====
// ----------------------------------------------------------------------------
// thp_comp_pkg
// Types, register indexes and helpers of the compensation core.
// ----------------------------------------------------------------------------
`default_nettype none

package thp_comp_pkg;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 104;

  // one quotient bit per stage of the 32-bit pressure divider
  localparam int unsigned DivStages = 32;

  localparam logic [CfgAddrW-1:0] CFG_TEMP_CAL    = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_PRESS_CAL_A = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_PRESS_CAL_B = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_PRESS_CAL_C = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_HUM_CAL_A   = 3'd4;
  localparam logic [CfgAddrW-1:0] CFG_HUM_CAL_B   = 3'd5;

  localparam logic [31:0] DIV100_MAGIC = 32'h51EB851F;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;

  typedef struct packed {
    logic [19:0] adc_t;
    logic [19:0] adc_p;
    logic [15:0] adc_h;
    logic [31:0] m0;
    logic [31:0] m1;
    logic [31:0] tf;
    logic [15:0] temp_out;
    logic [31:0] pa0;
    logic [31:0] ha;
    logic [31:0] pd;
    logic [31:0] mp5;
    logic [31:0] mp2;
    logic [31:0] mh5;
    logic [31:0] mh6;
    logic [31:0] mh3;
    logic [31:0] pbm;
    logic [31:0] mp3;
    logic [31:0] hbp;
    logic [31:0] hdx;
    logic [31:0] hdy;
    logic [31:0] pb;
    logic [31:0] pas;
    logic [31:0] hb;
    logic [31:0] mhd;
    logic [31:0] mp1;
    logic [31:0] pnum;
    logic [31:0] hd;
    logic [31:0] dvs;
    logic [31:0] mnum;
    logic [31:0] mhd2;
    logic        invalid;
    logic        dbl;
    logic [31:0] nq;
    logic [31:0] rem;
    logic [31:0] hd2;
    logic [31:0] mha;
    logic [31:0] sq;
    logic [31:0] mh1;
    logic [16:0] hum_q10;
    logic [6:0]  hum_pct;
    logic [31:0] pa;
    logic [31:0] msq;
    logic [31:0] mp8;
    logic [31:0] mp9;
    logic [31:0] pbb;
    logic [63:0] mhpa;
  } item_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] sh);
    return 32'($signed(x) >>> sh);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/thp_sensor_compensation_core.sv =====
// ----------------------------------------------------------------------------
// thp_sensor_compensation_core
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one raw sample set; output words carry the compensated
//   temperature, pressure (Pa and hPa, with an invalid flag on tuser) and
//   humidity. Calibration registers are loaded through cfg_wr_en/cfg_addr/
//   cfg_wdata; the user must load them while no word is in flight, as the
//   block does not enforce this. The pipeline has 14 arithmetic stages, a
//   32-stage radix-2 divider for the pressure quotient, and 4 stages of
//   pressure correction and divide-by-100. Throughput is one word per cycle
//   while out_tready is high. Each stage holds its own valid bit and
//   loads when it is empty or its successor moves, so bubbles collapse and
//   input is taken while a result waits at the output.
//   When out_tready is low the output word holds and stages fill up behind
//   it; in_tready drops only once every stage holds a word.
//   Synchronous reset clears all valid bits and the calibration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_sensor_compensation_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // temp_raw[19:0], press_raw[39:20], hum_raw[55:40]
  input  wire logic [thp_comp_pkg::InDataW-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // temp_centi[15:0], press_pa[47:16], press_hpa[73:48], hum_q10[90:74],
  // hum_percent[97:91], zero[103:98]
  output logic [thp_comp_pkg::OutDataW-1:0]    out_tdata,
  // press_invalid[0]
  output logic                                 out_tuser,
  input  wire logic                            cfg_wr_en,
  input  wire logic [thp_comp_pkg::CfgAddrW-1:0] cfg_addr,
  input  wire logic [thp_comp_pkg::CfgDataW-1:0] cfg_wdata
);

  localparam int unsigned DivFirst = 14;
  localparam int unsigned NStg     = DivFirst + thp_comp_pkg::DivStages + 4;

  logic [47:0] temp_cal_r;
  logic [63:0] press_cal_a_r;
  logic [63:0] press_cal_b_r;
  logic [15:0] press_cal_c_r;
  logic [47:0] hum_cal_a_r;
  logic [23:0] hum_cal_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r    <= '0;
      press_cal_a_r <= '0;
      press_cal_b_r <= '0;
      press_cal_c_r <= '0;
      hum_cal_a_r   <= '0;
      hum_cal_b_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        thp_comp_pkg::CFG_TEMP_CAL:    temp_cal_r    <= cfg_wdata[47:0];
        thp_comp_pkg::CFG_PRESS_CAL_A: press_cal_a_r <= cfg_wdata;
        thp_comp_pkg::CFG_PRESS_CAL_B: press_cal_b_r <= cfg_wdata;
        thp_comp_pkg::CFG_PRESS_CAL_C: press_cal_c_r <= cfg_wdata[15:0];
        thp_comp_pkg::CFG_HUM_CAL_A:   hum_cal_a_r   <= cfg_wdata[47:0];
        thp_comp_pkg::CFG_HUM_CAL_B:   hum_cal_b_r   <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {16'd0, temp_cal_r[15:0]};
  assign t2 = thp_comp_pkg::sx16(temp_cal_r[31:16]);
  assign t3 = thp_comp_pkg::sx16(temp_cal_r[47:32]);
  assign p1 = {16'd0, press_cal_a_r[15:0]};
  assign p2 = thp_comp_pkg::sx16(press_cal_a_r[31:16]);
  assign p3 = thp_comp_pkg::sx16(press_cal_a_r[47:32]);
  assign p4 = thp_comp_pkg::sx16(press_cal_a_r[63:48]);
  assign p5 = thp_comp_pkg::sx16(press_cal_b_r[15:0]);
  assign p6 = thp_comp_pkg::sx16(press_cal_b_r[31:16]);
  assign p7 = thp_comp_pkg::sx16(press_cal_b_r[47:32]);
  assign p8 = thp_comp_pkg::sx16(press_cal_b_r[63:48]);
  assign p9 = thp_comp_pkg::sx16(press_cal_c_r);
  assign h1 = {24'd0, hum_cal_a_r[7:0]};
  assign h2 = thp_comp_pkg::sx16(hum_cal_a_r[23:8]);
  assign h3 = {24'd0, hum_cal_a_r[31:24]};
  assign h4 = thp_comp_pkg::sx16(hum_cal_a_r[47:32]);
  assign h5 = thp_comp_pkg::sx16(hum_cal_b_r[15:0]);
  assign h6 = thp_comp_pkg::sx8(hum_cal_b_r[23:16]);

  thp_comp_pkg::item_t st_r   [NStg];
  thp_comp_pkg::item_t st_nxt [NStg];
  logic [NStg-1:0]     v_r;
  logic [NStg-1:0]     rdy;

  assign rdy[NStg-1] = !v_r[NStg-1] || out_tready;
  for (genvar g = 0; g < NStg - 1; g++) begin : g_rdy
    assign rdy[g] = !v_r[g] || rdy[g+1];
  end
  assign in_tready = rdy[0];

  always_comb begin
    logic [31:0] tx, td, t, q, pb, hs, hv, hq, pa, fin;
    logic [32:0] tr;
    logic        qb;
    tx = '0; td = '0; t = '0; q = '0; pb = '0; hs = '0; hv = '0; hq = '0;
    pa = '0; fin = '0; tr = '0; qb = 1'b0;

    // stage 0: temperature products
    st_nxt[0]       = st_r[0];
    st_nxt[0].adc_t = in_tdata[19:0];
    st_nxt[0].adc_p = in_tdata[39:20];
    st_nxt[0].adc_h = in_tdata[55:40];
    tx = ({12'd0, in_tdata[19:0]} >> 3) - (t1 << 1);
    td = ({12'd0, in_tdata[19:0]} >> 4) - t1;
    st_nxt[0].m0 = 32'(tx * t2);
    st_nxt[0].m1 = 32'(td * td);

    st_nxt[1]    = st_r[0];
    st_nxt[1].m0 = thp_comp_pkg::asr(st_r[0].m0, 5'd11);
    st_nxt[1].m1 = 32'(thp_comp_pkg::asr(st_r[0].m1, 5'd12) * t3);

    st_nxt[2]    = st_r[1];
    st_nxt[2].tf = st_r[1].m0 + thp_comp_pkg::asr(st_r[1].m1, 5'd14);

    st_nxt[3] = st_r[2];
    t = thp_comp_pkg::asr(32'(st_r[2].tf * 32'd5) + 32'd128, 5'd8);
    if (t[31]) begin
      st_nxt[3].temp_out = (t < 32'hFFFF8000) ? 16'h8000 : t[15:0];
    end else begin
      st_nxt[3].temp_out = (t > 32'd32767) ? 16'h7FFF : t[15:0];
    end
    st_nxt[3].pa0 = thp_comp_pkg::asr(st_r[2].tf, 5'd1) - 32'd64000;
    st_nxt[3].ha  = st_r[2].tf - 32'd76800;

    st_nxt[4]     = st_r[3];
    q             = thp_comp_pkg::asr(st_r[3].pa0, 5'd2);
    st_nxt[4].pd  = 32'(q * q);
    st_nxt[4].mp5 = 32'(st_r[3].pa0 * p5);
    st_nxt[4].mp2 = 32'(p2 * st_r[3].pa0);
    st_nxt[4].mh5 = 32'(h5 * st_r[3].ha);
    st_nxt[4].mh6 = 32'(st_r[3].ha * h6);
    st_nxt[4].mh3 = 32'(st_r[3].ha * h3);

    st_nxt[5]     = st_r[4];
    st_nxt[5].pbm = 32'(thp_comp_pkg::asr(st_r[4].pd, 5'd11) * p6);
    st_nxt[5].mp3 = 32'(p3 * thp_comp_pkg::asr(st_r[4].pd, 5'd13));
    st_nxt[5].hbp = (({16'd0, st_r[4].adc_h} << 14) - (h4 << 20) - st_r[4].mh5)
                    + 32'd16384;
    st_nxt[5].hdx = thp_comp_pkg::asr(st_r[4].mh6, 5'd10);
    st_nxt[5].hdy = thp_comp_pkg::asr(st_r[4].mh3, 5'd11) + 32'd32768;

    st_nxt[6]     = st_r[5];
    pb            = st_r[5].pbm + (st_r[5].mp5 << 1);
    st_nxt[6].pb  = thp_comp_pkg::asr(pb, 5'd2) + (p4 << 16);
    st_nxt[6].pas = thp_comp_pkg::asr(thp_comp_pkg::asr(st_r[5].mp3, 5'd3)
                    + thp_comp_pkg::asr(st_r[5].mp2, 5'd1), 5'd18);
    st_nxt[6].hb  = thp_comp_pkg::asr(st_r[5].hbp, 5'd15);
    st_nxt[6].mhd = 32'(st_r[5].hdx * st_r[5].hdy);

    st_nxt[7]      = st_r[6];
    st_nxt[7].mp1  = 32'((32'd32768 + st_r[6].pas) * p1);
    st_nxt[7].pnum = (32'd1048576 - {12'd0, st_r[6].adc_p})
                     - thp_comp_pkg::asr(st_r[6].pb, 5'd12);
    st_nxt[7].hd   = thp_comp_pkg::asr(st_r[6].mhd, 5'd10) + 32'd2097152;

    st_nxt[8]      = st_r[7];
    st_nxt[8].dvs  = thp_comp_pkg::asr(st_r[7].mp1, 5'd15);
    st_nxt[8].mnum = 32'(st_r[7].pnum * 32'd3125);
    st_nxt[8].mhd2 = 32'(st_r[7].hd * h2);

    st_nxt[9]         = st_r[8];
    st_nxt[9].invalid = (st_r[8].dvs == 32'd0);
    st_nxt[9].dbl     = st_r[8].mnum[31];
    st_nxt[9].nq      = st_r[8].mnum[31] ? st_r[8].mnum : (st_r[8].mnum << 1);
    st_nxt[9].rem     = '0;
    st_nxt[9].hd2     = thp_comp_pkg::asr(st_r[8].mhd2 + 32'd8192, 5'd14);

    st_nxt[10]     = st_r[9];
    st_nxt[10].mha = 32'(st_r[9].hb * st_r[9].hd2);

    st_nxt[11]    = st_r[10];
    hs            = thp_comp_pkg::asr(st_r[10].mha, 5'd15);
    st_nxt[11].sq = 32'(hs * hs);

    st_nxt[12]     = st_r[11];
    st_nxt[12].mh1 = 32'(thp_comp_pkg::asr(st_r[11].sq, 5'd7) * h1);

    st_nxt[13] = st_r[12];
    hv = st_r[12].mha - thp_comp_pkg::asr(st_r[12].mh1, 5'd4);
    if (hv[31]) begin
      hv = '0;
    end else if (hv > thp_comp_pkg::HUM_MAX) begin
      hv = thp_comp_pkg::HUM_MAX;
    end
    hq = hv >> 12;
    st_nxt[13].hum_q10 = hq[16:0];
    st_nxt[13].hum_pct = hq[16:10];

    // restoring divider, one quotient bit per stage
    for (int k = DivFirst; k < DivFirst + thp_comp_pkg::DivStages; k++) begin
      st_nxt[k] = st_r[k-1];
      tr = {st_r[k-1].rem, st_r[k-1].nq[31]};
      qb = (tr >= {1'b0, st_r[k-1].dvs});
      st_nxt[k].rem = qb ? 32'(tr - {1'b0, st_r[k-1].dvs}) : tr[31:0];
      st_nxt[k].nq  = {st_r[k-1].nq[30:0], qb};
    end

    st_nxt[NStg-4]     = st_r[NStg-5];
    pa = st_r[NStg-5].dbl ? (st_r[NStg-5].nq << 1) : st_r[NStg-5].nq;
    st_nxt[NStg-4].pa  = pa;
    st_nxt[NStg-4].msq = 32'((pa >> 3) * (pa >> 3));
    st_nxt[NStg-4].mp8 = 32'((pa >> 2) * p8);

    st_nxt[NStg-3]     = st_r[NStg-4];
    st_nxt[NStg-3].mp9 = 32'(p9 * (st_r[NStg-4].msq >> 13));
    st_nxt[NStg-3].pbb = thp_comp_pkg::asr(st_r[NStg-4].mp8, 5'd13);

    st_nxt[NStg-2] = st_r[NStg-3];
    fin = st_r[NStg-3].pa + thp_comp_pkg::asr(thp_comp_pkg::asr(st_r[NStg-3].mp9, 5'd12)
          + st_r[NStg-3].pbb + p7, 5'd4);
    st_nxt[NStg-2].pa = st_r[NStg-3].invalid ? 32'd0 : fin;

    st_nxt[NStg-1]      = st_r[NStg-2];
    st_nxt[NStg-1].mhpa = 64'(st_r[NStg-2].pa) * 64'(thp_comp_pkg::DIV100_MAGIC);
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NStg; k++) begin
      if (rdy[k]) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign out_tvalid = v_r[NStg-1];
  assign out_tuser  = st_r[NStg-1].invalid;
  assign out_tdata  = {6'd0, st_r[NStg-1].hum_pct, st_r[NStg-1].hum_q10,
                       st_r[NStg-1].mhpa[62:37], st_r[NStg-1].pa,
                       st_r[NStg-1].temp_out};

endmodule

`default_nettype wire

// ===== rtl/thp_comp_checker.sv =====
// ----------------------------------------------------------------------------
// thp_comp_checker
// Port-level checks of the compensation core, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thp_sensor_compensation_core_assert.svh"

module thp_comp_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [thp_comp_pkg::OutDataW-1:0]   out_tdata,
  input wire logic                                out_tuser
);

  `THP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))
  `THP_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata[73:16] == 58'd0)
  `THP_ASSERT_NOW(a_hum_pct, clk, rst_n, out_tvalid, out_tdata[97:91] == out_tdata[90:84])
  `THP_ASSERT_NOW(a_hum_range, clk, rst_n, out_tvalid, out_tdata[90:74] <= 17'd102400 && out_tdata[103:98] == 6'd0)

endmodule

bind thp_sensor_compensation_core thp_comp_checker u_thp_comp_checker (.*);

`default_nettype wire
